### rtl/tcc_pkg.sv
// Package for the typewriter carriage control core: codes, line geometry and glyph table.
`timescale 1ns / 1ps

package tcc_pkg;

   // Line geometry
   localparam int unsigned LINE_COLUMNS = 80;
   localparam int unsigned TAB_WIDTH    = 8;
   localparam int unsigned COL_W        = 7;
   localparam logic [COL_W-1:0] COL_MAX = 7'd127;

   typedef logic [5:0]       code_type;
   typedef logic [7:0]       glyph_type;
   typedef logic [COL_W-1:0] column_type;

   // Control codes
   localparam code_type C_BLACK = 6'o34;
   localparam code_type C_RED   = 6'o35;
   localparam code_type C_TAB   = 6'o36;
   localparam code_type C_LOWER = 6'o72;
   localparam code_type C_UPPER = 6'o74;
   localparam code_type C_BACK  = 6'o75;
   localparam code_type C_CR    = 6'o77;
   // Non-spacing printable codes
   localparam code_type C_NS_A  = 6'o40;
   localparam code_type C_NS_B  = 6'o56;

   // Lower case glyphs, 80h..87h are the special glyphs
   localparam glyph_type ROM_LOWER [64] = '{
      8'h20, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A,
      8'h30, 8'h2F, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
      8'h79, 8'h7A, 8'h2A, 8'h2C, 8'h2A, 8'h2A, 8'h2A, 8'h2A,
      8'h80, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70,
      8'h71, 8'h72, 8'h2A, 8'h2A, 8'h2D, 8'h29, 8'h81, 8'h28,
      8'h2A, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
      8'h68, 8'h69, 8'h2A, 8'h2E, 8'h2A, 8'h2A, 8'h2A, 8'h2A
   };

   // Upper case glyphs
   localparam glyph_type ROM_UPPER [64] = '{
      8'h20, 8'h22, 8'h27, 8'h7E, 8'h82, 8'h83, 8'h84, 8'h3C,
      8'h3E, 8'h85, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h2A,
      8'h86, 8'h3F, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
      8'h59, 8'h5A, 8'h2A, 8'h3D, 8'h2A, 8'h2A, 8'h2A, 8'h2A,
      8'h5F, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
      8'h51, 8'h52, 8'h2A, 8'h2A, 8'h2B, 8'h5D, 8'h7C, 8'h5B,
      8'h2A, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
      8'h48, 8'h49, 8'h2A, 8'h87, 8'h2A, 8'h2A, 8'h2A, 8'h2A
   };

   // Look up a glyph in the selected case
   function automatic glyph_type glyph_lookup(input logic upper, input code_type code);
      glyph_type g;
      g = upper ? ROM_UPPER[code] : ROM_LOWER[code];
      return g;
   endfunction

endpackage

### rtl/typewriter_carriage_control_core.sv
// Top level of the typewriter carriage control core.
`timescale 1ns / 1ps

// One typewriter code is taken per clock cycle and its result, if any, appears
// on the rsp_ channel in the next cycle: carriage state and the glyph table read
// sit in one short path from req_code to the result register. Colour, case, tab
// and backspace codes update state only and produce no transfer; carriage return
// gives a line feed result; every other code gives a glyph, preceded by a wrap
// line feed once the column reaches the line width. req_ready stays high while
// the result register is empty or being taken, so a stalled result holds every
// input code, including those that give no transfer, until it is taken.
module typewriter_carriage_control_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcc_pkg::code_type   req_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_line_feed,
   output logic                rsp_glyph_valid,
   output tcc_pkg::glyph_type  rsp_glyph,
   output tcc_pkg::column_type rsp_column,
   output logic                rsp_red_ink
);
   import tcc_pkg::*;

   column_type column_ff, column_in;
   logic       upper_ff, upper_in;
   logic       red_ff, red_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       lf_ff, lf_in;
   logic       gv_ff, gv_in;
   glyph_type  glyph_ff, glyph_in;
   column_type rcol_ff, rcol_in;
   logic       rred_ff, rred_in;

   logic       accept;
   logic       has_result;
   logic       wrap;
   column_type print_col;
   logic [COL_W:0] tab_sum;

   // Accept while the result register is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Tab target and wrap test
   assign tab_sum   = {1'b0, column_ff} - (COL_W+1)'({1'b0, column_ff} % (COL_W+1)'(TAB_WIDTH))
                      + (COL_W+1)'(TAB_WIDTH);
   assign wrap      = column_ff >= COL_W'(LINE_COLUMNS);
   assign print_col = wrap ? '0 : column_ff;

   // Decode the code into next state and result
   always_comb begin
      column_in  = column_ff;
      upper_in   = upper_ff;
      red_in     = red_ff;
      has_result = 1'b0;
      lf_in      = 1'b0;
      gv_in      = 1'b0;
      glyph_in   = '0;
      rcol_in    = '0;
      rred_in    = red_ff;
      unique case (req_code)
         C_BLACK: red_in = 1'b0;
         C_RED:   red_in = 1'b1;
         C_TAB: begin
            column_in = (tab_sum > {1'b0, COL_MAX}) ? COL_MAX : tab_sum[COL_W-1:0];
         end
         C_LOWER: upper_in = 1'b0;
         C_UPPER: upper_in = 1'b1;
         C_BACK: begin
            if (column_ff != '0) begin
               column_in = column_ff - 1'b1;
            end
         end
         C_CR: begin
            column_in  = '0;
            has_result = 1'b1;
            lf_in      = 1'b1;
         end
         default: begin
            has_result = 1'b1;
            lf_in      = wrap;
            gv_in      = 1'b1;
            glyph_in   = glyph_lookup(upper_ff, req_code);
            rcol_in    = print_col;
            if (req_code == C_NS_A || req_code == C_NS_B) begin
               column_in = print_col;
            end else begin
               column_in = print_col + 1'b1;
            end
         end
      endcase
   end

   // Load or drop the result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = has_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         upper_ff     <= 1'b0;
         red_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            column_ff <= column_in;
            upper_ff  <= upper_in;
            red_ff    <= red_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded on every accepted code that gives a transfer
   always_ff @(posedge clock) begin
      if (accept && has_result) begin
         lf_ff    <= lf_in;
         gv_ff    <= gv_in;
         glyph_ff <= glyph_in;
         rcol_ff  <= rcol_in;
         rred_ff  <= rred_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_feed   = lf_ff;
   assign rsp_glyph_valid = gv_ff;
   assign rsp_glyph       = glyph_ff;
   assign rsp_column      = rcol_ff;
   assign rsp_red_ink     = rred_ff;

endmodule

### rtl/tcc_checker.sv
// Port-level checks for the typewriter carriage control core, bound to the top level.
`timescale 1ns / 1ps

module tcc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input tcc_pkg::code_type   req_code,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_line_feed,
   input logic                rsp_glyph_valid,
   input tcc_pkg::glyph_type  rsp_glyph,
   input tcc_pkg::column_type rsp_column,
   input logic                rsp_red_ink
);
   import tcc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_feed)
         && $stable(rsp_glyph_valid) && $stable(rsp_glyph)
         && $stable(rsp_column) && $stable(rsp_red_ink))
      else $error("stalled result changed");

   // A result without a glyph is a carriage return at column zero
   a_cr_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_glyph_valid |-> rsp_line_feed && rsp_glyph == '0 && rsp_column == '0)
      else $error("result without glyph is not a carriage return");

   // Glyphs land inside the line
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_glyph_valid |-> rsp_column < COL_W'(LINE_COLUMNS))
      else $error("glyph column beyond line width");

   // A transferred carriage return shows up as a line feed in the next cycle
   a_cr_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_code == C_CR |=>
         rsp_valid && rsp_line_feed && !rsp_glyph_valid)
      else $error("carriage return gave no line feed");

endmodule

bind typewriter_carriage_control_core tcc_checker u_tcc_checker (.*);
